[rtl/ssi_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the segment intersection block
// no dependencies

package ssi_pkg;

  // depth of the queue between front and back, a power of two
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

[rtl/ssi_front.sv]
`timescale 1ns / 1ps
// front part: differences, cross products and the hit classification
// no package dependencies

module ssi_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  // entry from bit 0 up: hit, sx, sy, asx, asy, den_mag, numa_mag, dax_mag, day_mag
  output logic [4*COORD_WIDTH+2*(2*COORD_WIDTH+3)+4:0] out_data_o
);
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1 payload
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, ox_q, oy_q;
  logic signed [W-1:0]  asx1_q, asy1_q;
  // stage 2 payload
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [W-1:0]  asx2_q, asy2_q;
  // stage 3 payload
  logic signed [NW-1:0] den_q, na_q, nb_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [W-1:0]  asx3_q, asy3_q;
  // stage 4 payload
  logic            hit_q, sx_q, sy_q;
  logic [W-1:0]    asx4_q, asy4_q;
  logic [NW-1:0]   dmag_q, namag_q;
  logic [DW-1:0]   dxm_q, dym_q;

  // classification of stage 3
  logic den_neg, na_ok, nb_ok, hit_d;

  // whole pipeline moves unless the last stage is held
  assign en          = !v4_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: coordinate differences
  always_ff @(posedge clk_i) begin
    if (en) begin
      dax_q  <= DW'(a_end_x_i) - DW'(a_start_x_i);
      day_q  <= DW'(a_end_y_i) - DW'(a_start_y_i);
      dbx_q  <= DW'(b_end_x_i) - DW'(b_start_x_i);
      dby_q  <= DW'(b_end_y_i) - DW'(b_start_y_i);
      ox_q   <= DW'(a_start_x_i) - DW'(b_start_x_i);
      oy_q   <= DW'(a_start_y_i) - DW'(b_start_y_i);
      asx1_q <= a_start_x_i;
      asy1_q <= a_start_y_i;
    end
  end

  // stage 2: six cross products
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= PW'(dby_q) * PW'(dax_q);
      p2_q   <= PW'(dbx_q) * PW'(day_q);
      p3_q   <= PW'(dbx_q) * PW'(oy_q);
      p4_q   <= PW'(dby_q) * PW'(ox_q);
      p5_q   <= PW'(dax_q) * PW'(oy_q);
      p6_q   <= PW'(day_q) * PW'(ox_q);
      dax2_q <= dax_q;
      day2_q <= day_q;
      asx2_q <= asx1_q;
      asy2_q <= asy1_q;
    end
  end

  // stage 3: denominator and the two numerators
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q  <= NW'(p1_q) - NW'(p2_q);
      na_q   <= NW'(p3_q) - NW'(p4_q);
      nb_q   <= NW'(p5_q) - NW'(p6_q);
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      asx3_q <= asx2_q;
      asy3_q <= asy2_q;
    end
  end

  // both parameters in [0,1], sign aware, no division
  always_comb begin
    den_neg = den_q[NW-1];
    if (den_neg) begin
      na_ok = (na_q <= 0) && (na_q >= den_q);
      nb_ok = (nb_q <= 0) && (nb_q >= den_q);
    end else begin
      na_ok = (na_q >= 0) && (na_q <= den_q);
      nb_ok = (nb_q >= 0) && (nb_q <= den_q);
    end
    hit_d = (den_q != '0) && na_ok && nb_ok;
  end

  // stage 4: hit flag, magnitudes and quotient signs
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_d;
      sx_q    <= na_q[NW-1] ^ den_neg ^ dax3_q[DW-1];
      sy_q    <= na_q[NW-1] ^ den_neg ^ day3_q[DW-1];
      asx4_q  <= asx3_q;
      asy4_q  <= asy3_q;
      dmag_q  <= den_neg ? NW'(-den_q) : NW'(den_q);
      namag_q <= na_q[NW-1] ? NW'(-na_q) : NW'(na_q);
      dxm_q   <= dax3_q[DW-1] ? DW'(-dax3_q) : DW'(dax3_q);
      dym_q   <= day3_q[DW-1] ? DW'(-day3_q) : DW'(day3_q);
    end
  end

  assign out_data_o = {dym_q, dxm_q, namag_q, dmag_q, asy4_q, asx4_q, sy_q, sx_q, hit_q};

endmodule

[rtl/ssi_queue.sv]
`timescale 1ns / 1ps
// short queue between the front and back parts
// depends on ssi_pkg for the depth

module ssi_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import ssi_pkg::*;

  logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

[rtl/ssi_back.sv]
`timescale 1ns / 1ps
// back part: numerator times direction, pipelined divide, offset and saturate
// no package dependencies

module ssi_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  // entry from bit 0 up: hit, sx, sy, asx, asy, den_mag, numa_mag, dax_mag, day_mag
  input  logic [4*COORD_WIDTH+2*(2*COORD_WIDTH+3)+4:0] in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic [COORD_WIDTH-1:0] point_x_o,
  output logic [COORD_WIDTH-1:0] point_y_o
);
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int NW = 2 * W + 3;
  localparam int H  = (NW + 1) / 2;
  localparam int RW = NW + DW;
  localparam int NS = W + 3;

  // first member sits in the top bits, so hit ends up at bit 0
  typedef struct packed {
    logic [NW-1:0] dmag;
    logic [W-1:0]  asy;
    logic [W-1:0]  asx;
    logic          sy;
    logic          sx;
    logic          hit;
  } side_t;

  side_t         in_side;
  logic [NW-1:0] in_namag;
  logic [DW-1:0] in_dxm, in_dym;

  logic          en;
  logic [NS-1:0] vld_q;

  logic [H+DW-1:0]      plo_x_q, plo_y_q;
  logic [NW-H+DW-1:0]   phi_x_q, phi_y_q;
  side_t                b0_side_q;

  side_t        side_q  [W+1];
  logic [RW-1:0] rx_q   [W+1];
  logic [RW-1:0] ry_q   [W+1];
  logic [W-1:0]  qx_q   [W+1];
  logic [W-1:0]  qy_q   [W+1];
  logic [RW-1:0] rx_d   [W];
  logic [RW-1:0] ry_d   [W];
  logic [W-1:0]  qx_d   [W];
  logic [W-1:0]  qy_d   [W];

  logic [W+1:0] sum_x, sum_y;
  logic [W-1:0] px_d, py_d;
  logic         hit_q;
  logic [W-1:0] px_q, py_q;

  assign {in_dym, in_dxm, in_namag, in_side} = in_data_i;

  // stall-all pipeline, the last stage is the output register
  assign en          = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // partial products of the numerator halves
  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_x_q   <= (H+DW)'(in_namag[H-1:0]) * (H+DW)'(in_dxm);
      plo_y_q   <= (H+DW)'(in_namag[H-1:0]) * (H+DW)'(in_dym);
      phi_x_q   <= (NW-H+DW)'(in_namag[NW-1:H]) * (NW-H+DW)'(in_dxm);
      phi_y_q   <= (NW-H+DW)'(in_namag[NW-1:H]) * (NW-H+DW)'(in_dym);
      b0_side_q <= in_side;
    end
  end

  // one restoring divide step per stage, quotient msb first
  always_comb begin
    for (int k = 0; k < W; k++) begin
      logic [RW-1:0] dsh;
      dsh = RW'(side_q[k].dmag) << (W - 1 - k);
      if (rx_q[k] >= dsh) begin
        rx_d[k] = rx_q[k] - dsh;
        qx_d[k] = {qx_q[k][W-2:0], 1'b1};
      end else begin
        rx_d[k] = rx_q[k];
        qx_d[k] = {qx_q[k][W-2:0], 1'b0};
      end
      if (ry_q[k] >= dsh) begin
        ry_d[k] = ry_q[k] - dsh;
        qy_d[k] = {qy_q[k][W-2:0], 1'b1};
      end else begin
        ry_d[k] = ry_q[k];
        qy_d[k] = {qy_q[k][W-2:0], 1'b0};
      end
    end
  end

  // dividend assembly and divider stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]   <= RW'(plo_x_q) + (RW'(phi_x_q) << H);
      ry_q[0]   <= RW'(plo_y_q) + (RW'(phi_y_q) << H);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      side_q[0] <= b0_side_q;
      for (int k = 0; k < W; k++) begin
        rx_q[k+1]   <= rx_d[k];
        ry_q[k+1]   <= ry_d[k];
        qx_q[k+1]   <= qx_d[k];
        qy_q[k+1]   <= qy_d[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // signed quotient plus start point, saturated
  always_comb begin
    sum_x = {{2{side_q[W].asx[W-1]}}, side_q[W].asx}
          + (side_q[W].sx ? (W+2)'(0) - {2'b00, qx_q[W]} : {2'b00, qx_q[W]});
    sum_y = {{2{side_q[W].asy[W-1]}}, side_q[W].asy}
          + (side_q[W].sy ? (W+2)'(0) - {2'b00, qy_q[W]} : {2'b00, qy_q[W]});
    if (sum_x[W+1:W-1] == '0 || sum_x[W+1:W-1] == '1) px_d = sum_x[W-1:0];
    else px_d = sum_x[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    if (sum_y[W+1:W-1] == '0 || sum_y[W+1:W-1] == '1) py_d = sum_y[W-1:0];
    else py_d = sum_y[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  end

  // output register, point reads zero on a miss
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= side_q[W].hit;
      px_q  <= side_q[W].hit ? px_d : '0;
      py_q  <= side_q[W].hit ? py_d : '0;
    end
  end

  assign hit_o     = hit_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;

endmodule

[rtl/segment_segment_intersect.sv]
`timescale 1ns / 1ps
// top level of the two-segment intersection test on signed fixed-point points
// depends on ssi_front, ssi_queue and ssi_back
//
//  channel  | direction | tdata (bit 0 up)                         | tuser
//  s_axis   | in        | a_start_x a_start_y a_end_x a_end_y      | -
//           |           | b_start_x b_start_y b_end_x b_end_y      |
//  m_axis   | out       | point_x point_y                          | hit
//
// throughput is one segment pair per cycle when nothing stalls; a pair passes
// through 4 front stages, the queue and COORD_WIDTH + 3 back stages
// the divider in the back part forms one quotient bit per stage
// reset clears all valid flags and the queue; no payload is reset
// a held output stalls the back, a full queue stalls the front and s_axis_tready_o

module segment_segment_intersect #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // point_x, point_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // hit
  output logic m_axis_tuser_o
);
  localparam int W  = COORD_WIDTH;
  localparam int NW = 2 * W + 3;
  localparam int EW = 4 * W + 2 * NW + 5;
  localparam int OW = ((2 * W + 7) / 8) * 8;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [EW-1:0] f_data, b_data;
  logic [W-1:0]  point_x, point_y;

  ssi_front #(.COORD_WIDTH(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .a_start_x_i (s_axis_tdata_i[0*W +: W]),
    .a_start_y_i (s_axis_tdata_i[1*W +: W]),
    .a_end_x_i   (s_axis_tdata_i[2*W +: W]),
    .a_end_y_i   (s_axis_tdata_i[3*W +: W]),
    .b_start_x_i (s_axis_tdata_i[4*W +: W]),
    .b_start_y_i (s_axis_tdata_i[5*W +: W]),
    .b_end_x_i   (s_axis_tdata_i[6*W +: W]),
    .b_end_y_i   (s_axis_tdata_i[7*W +: W]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  ssi_queue #(.WIDTH(EW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  ssi_back #(.COORD_WIDTH(W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_data_i   (b_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hit_o       (m_axis_tuser_o),
    .point_x_o   (point_x),
    .point_y_o   (point_y)
  );

  assign m_axis_tdata_o = OW'({point_y, point_x});

endmodule

[rtl/ssi_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the segment intersection block, bound to the top level
// depends on segment_segment_intersect

module ssi_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid_i,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  input logic m_axis_tuser_o
);
  logic       in_xfer, out_xfer;
  logic [7:0] pend_q;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // pairs taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else if (in_xfer && !out_xfer) pend_q <= pend_q + 1'b1;
    else if (out_xfer && !in_xfer) pend_q <= pend_q - 1'b1;
  end

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // every result comes from an accepted pair
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != '0)
    else $error("result without an accepted pair");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("miss with nonzero point");

endmodule

bind segment_segment_intersect ssi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ssi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
